/* rtl/core/jrs_pkg.sv */
// Shared types, widths and the sort-key helper function of the Johnson-rule sequencer.
`default_nettype none
package jrs_pkg;

  localparam int MAX_JOBS_DEF = 32;
  localparam int ID_W         = 16;
  localparam int TIME_W       = 16;
  localparam int KEY_W        = TIME_W + 1;
  localparam int SK_W         = KEY_W + 1;

  // A stored job: its id and one sort key in which a smaller value goes first.
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [SK_W-1:0] sk;
  } entry_t;

  // Chain-wide control for one cycle.
  typedef struct packed {
    logic insert;
    logic shift_up;
  } cell_ctrl_t;

  // Group one (t1 <= t2) sorts ascending by t1, group two descending by t2.
  // Placing the group in the top bit and inverting the group-two key folds
  // both orders into one unsigned ascending compare.
  function automatic logic [SK_W-1:0] make_sort_key(
    input logic [TIME_W-1:0] time_first,
    input logic [TIME_W-1:0] time_second,
    input logic [TIME_W-1:0] lag
  );
    logic [KEY_W-1:0] t1;
    logic [KEY_W-1:0] t2;
    t1 = {1'b0, time_first} + {1'b0, lag};
    t2 = {1'b0, time_second} + {1'b0, lag};
    if (t1 <= t2) begin
      return {1'b0, t1};
    end else begin
      return {1'b1, ~t2};
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/core/johnson_rule_sequencer_top.sv */
// Top level of the Johnson-rule sequencer: control and the chain of sorting cells.
`default_nettype none
// Jobs are loaded one word per cycle: a word is taken at a clock edge where
// start is high and busy is low. Each job is placed into its sorted position
// in a row of MAX_JOBS cells in the same cycle, so loading runs at one job per
// clock. The order is group one (first time plus lag not above second time
// plus lag) ascending by that key, then group two descending by second time
// plus lag; equal keys keep arrival order. When the word marked last_job is
// taken, busy rises on the next cycle and the stored jobs stream out of the
// head of the chain one per clock, each shown for exactly one cycle with
// out_strobe high. The receiver cannot stall this stream, so it must take a
// word on every strobe. Busy stays high until the last stored job has been
// shown. out_seq_last marks the final word, and out_overflow is high on
// every word of a sequence during whose loading jobs were dropped because
// all cells were full. After the stream the chain is empty and the next load
// may begin.
module johnson_rule_sequencer_top #(
  parameter int MAX_JOBS = jrs_pkg::MAX_JOBS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [jrs_pkg::ID_W-1:0]    in_job_id,
  input  wire logic [jrs_pkg::TIME_W-1:0]  in_time_first,
  input  wire logic [jrs_pkg::TIME_W-1:0]  in_time_second,
  input  wire logic [jrs_pkg::TIME_W-1:0]  in_lag,
  input  wire logic                        in_last_job,
  output logic                             out_strobe,
  output logic [jrs_pkg::ID_W-1:0]         out_seq_job_id,
  output logic                             out_seq_last,
  output logic                             out_overflow
);

  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic             state_r;
  logic             state_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             ovf_r;
  logic             ovf_nxt;

  logic                accept;
  logic                has_room;
  jrs_pkg::entry_t     new_word;
  jrs_pkg::cell_ctrl_t ctrl;

  jrs_pkg::entry_t cell_word [MAX_JOBS];
  logic [MAX_JOBS-1:0] cell_before;

  assign busy     = (state_r == ST_EMIT);
  assign accept   = start && !busy;
  assign has_room = (count_r < CNT_W'(MAX_JOBS));

  assign new_word.id = in_job_id;
  assign new_word.sk = jrs_pkg::make_sort_key(in_time_first, in_time_second, in_lag);

  // Insertion happens only when a cell is free; emission shifts the chain
  // toward the head, one job per cycle.
  assign ctrl.insert   = accept && has_room;
  assign ctrl.shift_up = busy;

  // The head cell drives the job id port directly; the other result ports come from the control state while emitting.
  assign out_strobe     = busy;
  assign out_seq_job_id = cell_word[0].id;
  assign out_seq_last   = busy && (count_r == CNT_W'(1));
  assign out_overflow   = busy && ovf_r;

  // The count of stored jobs tells each cell whether it holds a job.
  genvar gi;
  generate
    for (gi = 0; gi < MAX_JOBS; gi++) begin : g_cell
      jrs_pkg::entry_t prev_w;
      jrs_pkg::entry_t next_w;
      logic            prev_b;

      if (gi == 0) begin : g_head
        assign prev_w = new_word;
        assign prev_b = 1'b0;
      end else begin : g_body
        assign prev_w = cell_word[gi-1];
        assign prev_b = cell_before[gi-1];
      end

      if (gi == MAX_JOBS - 1) begin : g_tail
        assign next_w = '0;
      end else begin : g_inner
        assign next_w = cell_word[gi+1];
      end

      jrs_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occupied    (count_r > CNT_W'(gi)),
        .new_word    (new_word),
        .prev_before (prev_b),
        .prev_word   (prev_w),
        .next_word   (next_w),
        .ahead       (cell_before[gi]),
        .word        (cell_word[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (has_room) begin
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_job) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        count_nxt = count_r - CNT_W'(1);
        if (count_r == CNT_W'(1)) begin
          state_nxt = ST_LOAD;
          ovf_nxt   = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/jrs_cell.sv */
// One cell of the sorted insertion chain; holds one job.
`default_nettype none
module jrs_cell (
  input  wire logic               clk,
  input  wire jrs_pkg::cell_ctrl_t ctrl,
  input  wire logic               occupied,
  input  wire jrs_pkg::entry_t    new_word,
  input  wire logic               prev_before,
  input  wire jrs_pkg::entry_t    prev_word,
  input  wire jrs_pkg::entry_t    next_word,
  output logic                    ahead,
  output jrs_pkg::entry_t         word
);

  jrs_pkg::entry_t word_r;
  jrs_pkg::entry_t word_nxt;

  // Strict compare keeps equal keys in arrival order.
  assign ahead = !occupied || (new_word.sk < word_r.sk);
  assign word  = word_r;

  always_comb begin
    word_nxt = word_r;
    if (ctrl.shift_up) begin
      word_nxt = next_word;
    end else if (ctrl.insert && ahead) begin
      word_nxt = prev_before ? prev_word : new_word;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule
`default_nettype wire
